@@ rtl/dpe_pkg.sv @@
// Shared types, codes and helper functions for the data-processing encoder.
// No dependencies; every other file but dpe_ifs refers to it by scoped names.
`default_nettype none

package dpe_pkg;

  // Operation codes as they arrive on the instruction channel
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_ADC = 3'd1;
  localparam logic [2:0] OP_SUB = 3'd2;
  localparam logic [2:0] OP_SBC = 3'd3;
  localparam logic [2:0] OP_RSB = 3'd4;
  localparam logic [2:0] OP_RSC = 3'd5;

  // Command field values, bits 24:21 of the word
  localparam logic [3:0] CMD_ADD = 4'b0100;
  localparam logic [3:0] CMD_ADC = 4'b0101;
  localparam logic [3:0] CMD_SUB = 4'b0010;
  localparam logic [3:0] CMD_SBC = 4'b0110;
  localparam logic [3:0] CMD_RSB = 4'b0011;
  localparam logic [3:0] CMD_RSC = 4'b0111;

  // Shift kinds on the input side
  localparam logic [2:0] SHK_LSL = 3'd0;
  localparam logic [2:0] SHK_LSR = 3'd1;
  localparam logic [2:0] SHK_ASR = 3'd2;
  localparam logic [2:0] SHK_ROR = 3'd3;
  localparam logic [2:0] SHK_RRX = 3'd4;

  // Shift type field, bits 6:5 of the word
  localparam logic [1:0] SH_LSL = 2'b00;
  localparam logic [1:0] SH_LSR = 2'b01;
  localparam logic [1:0] SH_ASR = 2'b10;
  localparam logic [1:0] SH_ROR = 2'b11;

  // Error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_IMM   = 2'd1;
  localparam logic [1:0] ERR_SHIFT = 2'd2;

  localparam int unsigned NUM_ROT = 16;

  // Encoded register operand: shamt5, type, 0, Rm
  typedef struct packed {
    logic        ok;
    logic [11:0] field;
  } shift_enc_t;

  // Encoded immediate operand: rot4, imm8
  typedef struct packed {
    logic        ok;
    logic [11:0] field;
  } imm_enc_t;

  // One instruction word as captured from the input channel
  typedef struct packed {
    logic [2:0]  operation;
    logic        set_flags;
    logic [3:0]  condition;
    logic [3:0]  dest_reg;
    logic [3:0]  first_reg;
    logic        use_immediate;
    logic [31:0] immediate_value;
    logic [3:0]  second_reg;
    logic [2:0]  shift_kind;
    logic [5:0]  shift_amount;
  } item_t;

  // Middle stage contents
  typedef struct packed {
    logic [3:0]         condition;
    logic [3:0]         cmd;
    logic               set_flags;
    logic [3:0]         first_reg;
    logic [3:0]         dest_reg;
    logic               use_immediate;
    logic [31:0]        immediate_value;
    logic [NUM_ROT-1:0] hit;
    shift_enc_t         shf;
  } mid_t;

  // Map an operation to its command field; undefined codes encode as ADD
  function automatic logic [3:0] cmd_of(input logic [2:0] op);
    logic [3:0] c;
    unique case (op)
      OP_ADD:  c = CMD_ADD;
      OP_ADC:  c = CMD_ADC;
      OP_SUB:  c = CMD_SUB;
      OP_SBC:  c = CMD_SBC;
      OP_RSB:  c = CMD_RSB;
      OP_RSC:  c = CMD_RSC;
      default: c = CMD_ADD;
    endcase
    return c;
  endfunction

  // Rotate left by twice the given step
  function automatic logic [31:0] rotl_even(input logic [31:0] val, input logic [3:0] step);
    logic [63:0] d;
    d = {val, val} << {step, 1'b0};
    return d[63:32];
  endfunction

endpackage

`default_nettype wire

@@ rtl/dpe_ifs.sv @@
// Channel interfaces: instruction words in, encoded words out.
// Depends on nothing; uses plain valid/ready handshakes.
`default_nettype none

interface dpe_instr_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic        set_flags;
  logic [3:0]  condition;
  logic [3:0]  dest_reg;
  logic [3:0]  first_reg;
  logic        use_immediate;
  logic [31:0] immediate_value;
  logic [3:0]  second_reg;
  logic [2:0]  shift_kind;
  logic [5:0]  shift_amount;

  modport source (output valid, operation, set_flags, condition, dest_reg, first_reg,
                  use_immediate, immediate_value, second_reg, shift_kind, shift_amount,
                  input ready);
  modport sink (input valid, operation, set_flags, condition, dest_reg, first_reg,
                use_immediate, immediate_value, second_reg, shift_kind, shift_amount,
                output ready);
endinterface

interface dpe_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;
  logic [1:0]  error_code;

  modport source (output valid, instruction_word, error_code, input ready);
  modport sink (input valid, instruction_word, error_code, output ready);
endinterface

`default_nettype wire

@@ rtl/dpe_rot_scan.sv @@
// Immediate rotation scan: flags every even rotation that fits in 8 bits.
// Depends on dpe_pkg.
`default_nettype none

module dpe_rot_scan (
  input  wire logic [31:0]                  val,
  output logic      [dpe_pkg::NUM_ROT-1:0] hit
);

  // One independent check per rotation step
  always_comb begin
    for (int i = 0; i < dpe_pkg::NUM_ROT; i++) begin
      hit[i] = (dpe_pkg::rotl_even(val, 4'(i)) >> 8) == 32'd0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/dpe_rot_pick.sv @@
// Picks the smallest fitting rotation and builds the 12-bit immediate field.
// Depends on dpe_pkg.
`default_nettype none

module dpe_rot_pick (
  input  wire logic [31:0]                  val,
  input  wire logic [dpe_pkg::NUM_ROT-1:0]  hit,
  output dpe_pkg::imm_enc_t                 enc
);

  logic [3:0]  sel;
  logic [31:0] rotated;

  // Priority encode, lowest step wins
  always_comb begin
    sel = '0;
    for (int i = dpe_pkg::NUM_ROT - 1; i >= 0; i--) begin
      if (hit[i]) begin
        sel = 4'(i);
      end
    end
  end

  assign rotated   = dpe_pkg::rotl_even(val, sel);
  assign enc.ok    = |hit;
  assign enc.field = {sel, rotated[7:0]};

endmodule

`default_nettype wire

@@ rtl/dpe_shift_enc.sv @@
// Register-operand encoder: range check of the shift amount and field packing.
// Depends on dpe_pkg.
`default_nettype none

module dpe_shift_enc (
  input  wire logic [3:0]  second_reg,
  input  wire logic [2:0]  shift_kind,
  input  wire logic [5:0]  shift_amount,
  output dpe_pkg::shift_enc_t enc
);

  logic [1:0] sh;
  logic [4:0] shamt;
  logic       ok;

  // LSR/ASR by 32 wraps to 0; unknown kinds act as LSL
  always_comb begin
    unique case (shift_kind)
      dpe_pkg::SHK_LSR: begin
        sh    = dpe_pkg::SH_LSR;
        ok    = (shift_amount >= 6'd1) && (shift_amount <= 6'd32);
        shamt = shift_amount[4:0];
      end
      dpe_pkg::SHK_ASR: begin
        sh    = dpe_pkg::SH_ASR;
        ok    = (shift_amount >= 6'd1) && (shift_amount <= 6'd32);
        shamt = shift_amount[4:0];
      end
      dpe_pkg::SHK_ROR: begin
        sh    = dpe_pkg::SH_ROR;
        ok    = (shift_amount >= 6'd1) && (shift_amount <= 6'd31);
        shamt = shift_amount[4:0];
      end
      dpe_pkg::SHK_RRX: begin
        sh    = dpe_pkg::SH_ROR;
        ok    = 1'b1;
        shamt = 5'd0;
      end
      default: begin
        sh    = dpe_pkg::SH_LSL;
        ok    = shift_amount <= 6'd31;
        shamt = shift_amount[4:0];
      end
    endcase
  end

  assign enc.ok    = ok;
  assign enc.field = {shamt, sh, 1'b0, second_reg};

endmodule

`default_nettype wire

@@ rtl/data_processing_instruction_encoder.sv @@
// Top level: three-stage pipeline packing arithmetic instructions into words.
// Depends on dpe_pkg, dpe_ifs, dpe_rot_scan, dpe_rot_pick and dpe_shift_enc.
//
// Usage:
//   instr (sink)  takes one decoded ADD/ADC/SUB/SBC/RSB/RSC instruction per word.
//   enc  (source) gives one 32-bit instruction word plus an error code per input.
//   A word accepted on instr is registered in stage 1, then stage 2, then stage 3,
//   whose register drives enc; one word per cycle is sustained while enc.ready is high. Stage 1
//   captures the input, checks all 16 immediate rotations
//   and the shift range; stage 2 picks the smallest rotation and packs the word;
//   stage 3 is the output register.
//   Each stage loads whenever it is empty or the next stage moves, so bubbles are
//   squeezed out and a word waiting on enc does not stop earlier stages from
//   filling. When enc is stalled with all three stages full, instr.ready drops.
//   A word is zero whenever the error code is nonzero.
//   Synchronous reset (rst) empties all stages; no word is in flight afterwards.
`default_nettype none

module data_processing_instruction_encoder (
  input  wire logic       clk,
  input  wire logic       rst,
  dpe_instr_if.sink       instr,
  dpe_word_if.source      enc
);

  // Stage valids and advance enables
  logic v1, v2, v3;
  logic ld1, ld2, ld3;

  dpe_pkg::item_t   s1;
  dpe_pkg::mid_t    s2;
  dpe_pkg::mid_t    s2_next;
  logic [31:0]      word;
  logic [1:0]       err;
  logic [31:0]      word_next;
  logic [1:0]       err_next;

  logic [dpe_pkg::NUM_ROT-1:0] hit;
  dpe_pkg::shift_enc_t         shf;
  dpe_pkg::imm_enc_t           imm;

  assign ld3         = !v3 || enc.ready;
  assign ld2         = !v2 || ld3;
  assign ld1         = !v1 || ld2;
  assign instr.ready = ld1;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ld1) v1 <= instr.valid;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
    end
  end

  // Stage 1: input capture
  always_ff @(posedge clk) begin
    if (ld1) begin
      s1.operation       <= instr.operation;
      s1.set_flags       <= instr.set_flags;
      s1.condition       <= instr.condition;
      s1.dest_reg        <= instr.dest_reg;
      s1.first_reg       <= instr.first_reg;
      s1.use_immediate   <= instr.use_immediate;
      s1.immediate_value <= instr.immediate_value;
      s1.second_reg      <= instr.second_reg;
      s1.shift_kind      <= instr.shift_kind;
      s1.shift_amount    <= instr.shift_amount;
    end
  end

  dpe_rot_scan u_scan (
    .val (s1.immediate_value),
    .hit (hit)
  );

  dpe_shift_enc u_shift (
    .second_reg   (s1.second_reg),
    .shift_kind   (s1.shift_kind),
    .shift_amount (s1.shift_amount),
    .enc          (shf)
  );

  always_comb begin
    s2_next.condition       = s1.condition;
    s2_next.cmd             = dpe_pkg::cmd_of(s1.operation);
    s2_next.set_flags       = s1.set_flags;
    s2_next.first_reg       = s1.first_reg;
    s2_next.dest_reg        = s1.dest_reg;
    s2_next.use_immediate   = s1.use_immediate;
    s2_next.immediate_value = s1.immediate_value;
    s2_next.hit             = hit;
    s2_next.shf             = shf;
  end

  // Stage 2: rotation and range results
  always_ff @(posedge clk) begin
    if (ld2) begin
      s2 <= s2_next;
    end
  end

  dpe_rot_pick u_pick (
    .val (s2.immediate_value),
    .hit (s2.hit),
    .enc (imm)
  );

  // Word assembly; zero on any error
  always_comb begin
    logic [11:0] src2;
    logic        ok;
    if (s2.use_immediate) begin
      src2 = imm.field;
      ok   = imm.ok;
    end else begin
      src2 = s2.shf.field;
      ok   = s2.shf.ok;
    end
    if (ok) begin
      word_next = {s2.condition, 2'b00, s2.use_immediate, s2.cmd, s2.set_flags,
                   s2.first_reg, s2.dest_reg, src2};
      err_next  = dpe_pkg::ERR_NONE;
    end else begin
      word_next = '0;
      err_next  = s2.use_immediate ? dpe_pkg::ERR_IMM : dpe_pkg::ERR_SHIFT;
    end
  end

  // Stage 3: output register
  always_ff @(posedge clk) begin
    if (ld3) begin
      word <= word_next;
      err  <= err_next;
    end
  end

  assign enc.valid            = v3;
  assign enc.instruction_word = word;
  assign enc.error_code       = err;

endmodule

`default_nettype wire

@@ rtl/dpe_checker.sv @@
// Port-level checks on the encoder's output channel, bound to the top level.
// Depends on dpe_pkg and data_processing_instruction_encoder.
`default_nettype none

module dpe_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_word,
  input wire logic [1:0]  out_err
);

  // Pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // Any error forces a zero word
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_err != dpe_pkg::ERR_NONE) |-> out_word == 32'd0)
    else $error("nonzero word with error flagged");

  // Only defined error codes appear
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_err == dpe_pkg::ERR_NONE || out_err == dpe_pkg::ERR_IMM ||
                   out_err == dpe_pkg::ERR_SHIFT))
    else $error("undefined error code");

  // Register operand keeps bit 4 clear
  a_reg_bit4: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_err == dpe_pkg::ERR_NONE && !out_word[25]) |-> !out_word[4])
    else $error("bit 4 set in register-operand word");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_word) && $stable(out_err)))
    else $error("stalled result changed");

endmodule

bind data_processing_instruction_encoder dpe_checker u_dpe_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (enc.valid),
  .out_ready (enc.ready),
  .out_word  (enc.instruction_word),
  .out_err   (enc.error_code)
);

`default_nettype wire
